/* design/bcir_pkg.sv */
// ----------------------------------------------------------------------------
// bcir_pkg
// Shared constants and types for the boxcar average and IIR smoother.
// ----------------------------------------------------------------------------
`default_nettype none

package bcir_pkg;

   localparam int NUM_ADC      = 4;
   localparam int CH_KEY       = 0;
   localparam int CH_POT       = 1;
   localparam int CH_BATTERY   = 2;
   localparam int CH_CURRENT   = 3;

   localparam int WEIGHT_BITS  = 16;
   localparam int DEF_WINDOW   = 16;
   localparam int DEF_ADC_BITS = 12;

   localparam int ALPHA_BITS   = 17;
   localparam int Q16_SHIFT    = 16;
   localparam logic [ALPHA_BITS-1:0] Q16_ONE  = 17'h10000;
   localparam logic [ALPHA_BITS-1:0] Q16_HALF = 17'h08000;

   localparam logic [ALPHA_BITS-1:0] ALPHA_POT_RST     = 17'd65529;
   localparam logic [ALPHA_BITS-1:0] ALPHA_BATTERY_RST = 17'd6554;
   localparam logic [ALPHA_BITS-1:0] ALPHA_CURRENT_RST = 17'd6554;

   localparam int CSR_ADDR_BITS = 4;
   localparam int CSR_DATA_BITS = 32;
   localparam int REG_IDX_BITS  = 2;

   localparam logic [REG_IDX_BITS-1:0] REG_ALPHA_POT     = 2'd0;
   localparam logic [REG_IDX_BITS-1:0] REG_ALPHA_BATTERY = 2'd1;
   localparam logic [REG_IDX_BITS-1:0] REG_ALPHA_CURRENT = 2'd2;

   typedef struct packed {
      logic [ALPHA_BITS-1:0] pot;
      logic [ALPHA_BITS-1:0] battery;
      logic [ALPHA_BITS-1:0] current;
   } alpha_type;

endpackage

`default_nettype wire

/* design/boxcar_average_iir_smoother.sv */
// ----------------------------------------------------------------------------
// boxcar_average_iir_smoother
// Per-channel moving average over a sample ring, then exponential smoothing.
// ----------------------------------------------------------------------------
// Takes one sample set per clock while the result side does not stall, and
// returns one result per sample set, in order. The rate is set by the single
// ring memory, which is read and written at the same slot in the cycle a beat
// is accepted, and by the running-sum and filter registers, each updated once
// per beat. The ring needs no clearing pass after reset: a first-pass flag
// makes unwritten entries count as zero. The weights sit at byte addresses
// 0 (pot), 4 (battery) and 8 (current), Q1.16, values above 1.0 saturate.
// ----------------------------------------------------------------------------
`default_nettype none

module boxcar_average_iir_smoother #(
   parameter int WINDOW   = bcir_pkg::DEF_WINDOW,
   parameter int ADC_BITS = bcir_pkg::DEF_ADC_BITS
) (
   input  wire logic                                clock,
   input  wire logic                                reset,

   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic [ADC_BITS-1:0]                 req_raw_key,
   input  wire logic [ADC_BITS-1:0]                 req_raw_pot,
   input  wire logic [ADC_BITS-1:0]                 req_raw_battery,
   input  wire logic [ADC_BITS-1:0]                 req_raw_current,
   input  wire logic [bcir_pkg::WEIGHT_BITS-1:0]    req_raw_weight,

   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic      [ADC_BITS-1:0]                 rsp_mean_key,
   output logic      [ADC_BITS-1:0]                 rsp_mean_pot,
   output logic      [ADC_BITS-1:0]                 rsp_mean_battery,
   output logic      [ADC_BITS-1:0]                 rsp_mean_current,
   output logic      [bcir_pkg::WEIGHT_BITS-1:0]    rsp_mean_weight,
   output logic      [ADC_BITS-1:0]                 rsp_smooth_pot,
   output logic      [ADC_BITS-1:0]                 rsp_smooth_battery,
   output logic      [ADC_BITS-1:0]                 rsp_smooth_current,

   input  wire logic                                psel,
   input  wire logic                                penable,
   input  wire logic                                pwrite,
   input  wire logic [bcir_pkg::CSR_ADDR_BITS-1:0]  paddr,
   input  wire logic [bcir_pkg::CSR_DATA_BITS-1:0]  pwdata,
   output logic      [bcir_pkg::CSR_DATA_BITS-1:0]  prdata,
   output logic                                     pready
);

   localparam int NA = bcir_pkg::NUM_ADC;

   bcir_pkg::alpha_type               alpha;
   logic [ADC_BITS-1:0]               adc_in   [NA];
   logic [ADC_BITS-1:0]               win_mean [NA];
   logic [ADC_BITS-1:0]               out_mean [NA];
   logic [bcir_pkg::WEIGHT_BITS-1:0]  win_weight;
   logic                              win_valid;
   logic                              smooth_ready;

   assign adc_in[bcir_pkg::CH_KEY]     = req_raw_key;
   assign adc_in[bcir_pkg::CH_POT]     = req_raw_pot;
   assign adc_in[bcir_pkg::CH_BATTERY] = req_raw_battery;
   assign adc_in[bcir_pkg::CH_CURRENT] = req_raw_current;

   bcir_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .alpha   (alpha)
   );

   bcir_window #(
      .WINDOW   (WINDOW),
      .ADC_BITS (ADC_BITS)
   ) u_window (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .adc_in      (adc_in),
      .weight_in   (req_raw_weight),
      .out_valid   (win_valid),
      .out_ready   (smooth_ready),
      .adc_mean    (win_mean),
      .weight_mean (win_weight)
   );

   bcir_smooth #(
      .ADC_BITS (ADC_BITS)
   ) u_smooth (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (win_valid),
      .in_ready       (smooth_ready),
      .adc_mean       (win_mean),
      .weight_mean    (win_weight),
      .alpha          (alpha),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .mean_out       (out_mean),
      .weight_out     (rsp_mean_weight),
      .smooth_pot     (rsp_smooth_pot),
      .smooth_battery (rsp_smooth_battery),
      .smooth_current (rsp_smooth_current)
   );

   assign rsp_mean_key     = out_mean[bcir_pkg::CH_KEY];
   assign rsp_mean_pot     = out_mean[bcir_pkg::CH_POT];
   assign rsp_mean_battery = out_mean[bcir_pkg::CH_BATTERY];
   assign rsp_mean_current = out_mean[bcir_pkg::CH_CURRENT];

endmodule

`default_nettype wire

/* design/bcir_ram.sv */
// ----------------------------------------------------------------------------
// bcir_ram
// Generic single-write, single-read RAM with registered, read-first output.
// ----------------------------------------------------------------------------
`default_nettype none

module bcir_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* design/bcir_csr.sv */
// ----------------------------------------------------------------------------
// bcir_csr
// APB register file holding the three Q1.16 smoothing weights.
// ----------------------------------------------------------------------------
`default_nettype none

module bcir_csr (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                psel,
   input  wire logic                                penable,
   input  wire logic                                pwrite,
   input  wire logic [bcir_pkg::CSR_ADDR_BITS-1:0]  paddr,
   input  wire logic [bcir_pkg::CSR_DATA_BITS-1:0]  pwdata,
   output logic      [bcir_pkg::CSR_DATA_BITS-1:0]  prdata,
   output logic                                     pready,
   output bcir_pkg::alpha_type                      alpha
);

   localparam int PAD = bcir_pkg::CSR_DATA_BITS - bcir_pkg::ALPHA_BITS;

   logic                                  wr_beat;
   logic [bcir_pkg::REG_IDX_BITS-1:0]     reg_idx;
   logic [bcir_pkg::ALPHA_BITS-1:0]       wdata;
   bcir_pkg::alpha_type                   alpha_ff;
   bcir_pkg::alpha_type                   alpha_in;

   assign pready  = 1'b1;
   assign wr_beat = psel & penable & pwrite & pready;
   assign reg_idx = paddr[bcir_pkg::CSR_ADDR_BITS-1:2];
   assign wdata   = pwdata[bcir_pkg::ALPHA_BITS-1:0];

   always_comb begin
      alpha_in = alpha_ff;
      if (wr_beat) begin
         case (reg_idx)
            bcir_pkg::REG_ALPHA_POT:     alpha_in.pot     = wdata;
            bcir_pkg::REG_ALPHA_BATTERY: alpha_in.battery = wdata;
            bcir_pkg::REG_ALPHA_CURRENT: alpha_in.current = wdata;
            default:                     alpha_in         = alpha_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff.pot     <= bcir_pkg::ALPHA_POT_RST;
         alpha_ff.battery <= bcir_pkg::ALPHA_BATTERY_RST;
         alpha_ff.current <= bcir_pkg::ALPHA_CURRENT_RST;
      end else begin
         alpha_ff <= alpha_in;
      end
   end

   always_comb begin
      case (reg_idx)
         bcir_pkg::REG_ALPHA_POT:     prdata = {{PAD{1'b0}}, alpha_ff.pot};
         bcir_pkg::REG_ALPHA_BATTERY: prdata = {{PAD{1'b0}}, alpha_ff.battery};
         bcir_pkg::REG_ALPHA_CURRENT: prdata = {{PAD{1'b0}}, alpha_ff.current};
         default:                     prdata = '0;
      endcase
   end

   assign alpha = alpha_ff;

endmodule

`default_nettype wire

/* design/bcir_window.sv */
// ----------------------------------------------------------------------------
// bcir_window
// Sample ring in RAM, running sums and constant-reciprocal mean.
// ----------------------------------------------------------------------------
`default_nettype none

module bcir_window #(
   parameter int WINDOW   = bcir_pkg::DEF_WINDOW,
   parameter int ADC_BITS = bcir_pkg::DEF_ADC_BITS
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_stall,
   input  wire logic [ADC_BITS-1:0]              adc_in [bcir_pkg::NUM_ADC],
   input  wire logic [bcir_pkg::WEIGHT_BITS-1:0] weight_in,
   output logic                                  out_valid,
   input  wire logic                             out_ready,
   output logic      [ADC_BITS-1:0]              adc_mean [bcir_pkg::NUM_ADC],
   output logic      [bcir_pkg::WEIGHT_BITS-1:0] weight_mean
);

   localparam int NA      = bcir_pkg::NUM_ADC;
   localparam int WB      = bcir_pkg::WEIGHT_BITS;
   localparam int AW      = $clog2(WINDOW);
   localparam int SW      = ADC_BITS + AW;
   localparam int WSW     = WB + AW;
   localparam int ENTRY_W = NA * ADC_BITS + WB;
   localparam logic [AW-1:0] LAST_SLOT = AW'(WINDOW - 1);

   // floor(x/WINDOW) == (x*ceil(2^(N+AW)/WINDOW)) >> (N+AW) for x < 2^N
   localparam logic [63:0] ADC_NUM = 64'd1 << (SW + AW);
   localparam logic [63:0] WT_NUM  = 64'd1 << (WSW + AW);
   localparam logic [SW:0]  ADC_RECIP =
      (SW+1)'((ADC_NUM + 64'(WINDOW) - 64'd1) / 64'(WINDOW));
   localparam logic [WSW:0] WT_RECIP  =
      (WSW+1)'((WT_NUM + 64'(WINDOW) - 64'd1) / 64'(WINDOW));

   logic               a_ready, b_ready, c_ready;
   logic               accept, a_to_b, b_to_c;
   logic               a_valid_ff, a_valid_in;
   logic               b_valid_ff, b_valid_in;
   logic               c_valid_ff, c_valid_in;
   logic [AW-1:0]      slot_ff, slot_in;
   logic               full_ff, full_in;

   logic [ENTRY_W-1:0] ram_wdata;
   logic [ENTRY_W-1:0] ram_rdata;

   logic [ADC_BITS-1:0] a_adc_ff [NA];
   logic [WB-1:0]       a_weight_ff;
   logic                a_full_ff;
   logic [ADC_BITS-1:0] old_adc [NA];
   logic [WB-1:0]       old_weight;

   logic [SW-1:0]       adc_sum_ff [NA];
   logic [SW-1:0]       adc_sum_in [NA];
   logic [WSW-1:0]      weight_sum_ff, weight_sum_in;

   logic [2*SW:0]       adc_prod [NA];
   logic [2*WSW:0]      weight_prod;
   logic [ADC_BITS-1:0] adc_mean_ff [NA];
   logic [WB-1:0]       weight_mean_ff;

   assign c_ready   = !c_valid_ff || out_ready;
   assign b_ready   = !b_valid_ff || c_ready;
   assign a_ready   = !a_valid_ff || b_ready;
   assign req_stall = !a_ready;
   assign accept    = req_valid && a_ready;
   assign a_to_b    = a_valid_ff && b_ready;
   assign b_to_c    = b_valid_ff && c_ready;

   assign a_valid_in = accept | (a_valid_ff & !a_to_b);
   assign b_valid_in = a_to_b | (b_valid_ff & !b_to_c);
   assign c_valid_in = b_to_c | (c_valid_ff & !out_ready);

   always_comb begin
      slot_in = slot_ff;
      full_in = full_ff;
      if (accept) begin
         if (slot_ff == LAST_SLOT) begin
            slot_in = '0;
            full_in = 1'b1;
         end else begin
            slot_in = slot_ff + AW'(1);
         end
      end
   end

   generate
      for (genvar i = 0; i < NA; i++) begin : g_pack
         assign ram_wdata[i*ADC_BITS +: ADC_BITS] = adc_in[i];
      end
   endgenerate
   assign ram_wdata[ENTRY_W-1 -: WB] = weight_in;

   bcir_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (WINDOW)
   ) u_ring (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (slot_ff),
      .wr_data (ram_wdata),
      .rd_en   (accept),
      .rd_addr (slot_ff),
      .rd_data (ram_rdata)
   );

   // entries not yet written on the first pass read as zero
   generate
      for (genvar i = 0; i < NA; i++) begin : g_lane
         assign old_adc[i] = a_full_ff ? ram_rdata[i*ADC_BITS +: ADC_BITS] : '0;
         assign adc_sum_in[i] = a_to_b ?
            adc_sum_ff[i] + SW'(a_adc_ff[i]) - SW'(old_adc[i]) : adc_sum_ff[i];
         assign adc_prod[i] = {{(SW+1){1'b0}}, adc_sum_ff[i]} * {{SW{1'b0}}, ADC_RECIP};
         assign adc_mean[i] = adc_mean_ff[i];
      end
   endgenerate

   assign old_weight    = a_full_ff ? ram_rdata[ENTRY_W-1 -: WB] : '0;
   assign weight_sum_in = a_to_b ?
      weight_sum_ff + WSW'(a_weight_ff) - WSW'(old_weight) : weight_sum_ff;
   assign weight_prod   = {{(WSW+1){1'b0}}, weight_sum_ff} * {{WSW{1'b0}}, WT_RECIP};

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff    <= 1'b0;
         b_valid_ff    <= 1'b0;
         c_valid_ff    <= 1'b0;
         slot_ff       <= '0;
         full_ff       <= 1'b0;
         weight_sum_ff <= '0;
         for (int i = 0; i < NA; i++) begin
            adc_sum_ff[i] <= '0;
         end
      end else begin
         a_valid_ff    <= a_valid_in;
         b_valid_ff    <= b_valid_in;
         c_valid_ff    <= c_valid_in;
         slot_ff       <= slot_in;
         full_ff       <= full_in;
         weight_sum_ff <= weight_sum_in;
         for (int i = 0; i < NA; i++) begin
            adc_sum_ff[i] <= adc_sum_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         a_adc_ff    <= adc_in;
         a_weight_ff <= weight_in;
         a_full_ff   <= full_ff;
      end
      if (b_to_c) begin
         for (int i = 0; i < NA; i++) begin
            adc_mean_ff[i] <= adc_prod[i][SW+AW +: ADC_BITS];
         end
         weight_mean_ff <= weight_prod[WSW+AW +: WB];
      end
   end

   assign out_valid   = c_valid_ff;
   assign weight_mean = weight_mean_ff;

endmodule

`default_nettype wire

/* design/bcir_smooth.sv */
// ----------------------------------------------------------------------------
// bcir_smooth
// First-order low-pass on pot, battery and current means; output register.
// ----------------------------------------------------------------------------
`default_nettype none

module bcir_smooth #(
   parameter int ADC_BITS = bcir_pkg::DEF_ADC_BITS
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             in_valid,
   output logic                                  in_ready,
   input  wire logic [ADC_BITS-1:0]              adc_mean [bcir_pkg::NUM_ADC],
   input  wire logic [bcir_pkg::WEIGHT_BITS-1:0] weight_mean,
   input  wire bcir_pkg::alpha_type              alpha,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output logic      [ADC_BITS-1:0]              mean_out [bcir_pkg::NUM_ADC],
   output logic      [bcir_pkg::WEIGHT_BITS-1:0] weight_out,
   output logic      [ADC_BITS-1:0]              smooth_pot,
   output logic      [ADC_BITS-1:0]              smooth_battery,
   output logic      [ADC_BITS-1:0]              smooth_current
);

   localparam int NA    = bcir_pkg::NUM_ADC;
   localparam int AB    = bcir_pkg::ALPHA_BITS;
   localparam int NL    = 3;
   localparam int ACC_W = AB + ADC_BITS + 1;

   logic                                 take;
   logic                                 d_valid_ff, d_valid_in;
   logic [ADC_BITS-1:0]                  mean_ff [NA];
   logic [bcir_pkg::WEIGHT_BITS-1:0]     weight_ff;

   logic [AB-1:0]        lane_alpha [NL];
   logic [AB-1:0]        lane_bias  [NL];
   logic [ADC_BITS-1:0]  lane_mean  [NL];
   logic [AB-1:0]        a_sat      [NL];
   logic [AB-1:0]        a_rest     [NL];
   logic [ACC_W-1:0]     acc        [NL];
   logic [ADC_BITS-1:0]  y_ff       [NL];
   logic [ADC_BITS-1:0]  y_in       [NL];

   assign in_ready   = !d_valid_ff || !rsp_stall;
   assign take       = in_valid && in_ready;
   assign d_valid_in = take | (d_valid_ff & rsp_stall);

   assign lane_alpha[0] = alpha.pot;
   assign lane_alpha[1] = alpha.battery;
   assign lane_alpha[2] = alpha.current;
   assign lane_mean[0]  = adc_mean[bcir_pkg::CH_POT];
   assign lane_mean[1]  = adc_mean[bcir_pkg::CH_BATTERY];
   assign lane_mean[2]  = adc_mean[bcir_pkg::CH_CURRENT];
   // current rounds to nearest, the others truncate
   assign lane_bias[0]  = '0;
   assign lane_bias[1]  = '0;
   assign lane_bias[2]  = bcir_pkg::Q16_HALF;

   generate
      for (genvar i = 0; i < NL; i++) begin : g_lpf
         assign a_sat[i]  = (lane_alpha[i] > bcir_pkg::Q16_ONE) ?
                            bcir_pkg::Q16_ONE : lane_alpha[i];
         assign a_rest[i] = bcir_pkg::Q16_ONE - a_sat[i];
         assign acc[i]    = ACC_W'(a_sat[i]) * ACC_W'(lane_mean[i])
                          + ACC_W'(a_rest[i]) * ACC_W'(y_ff[i])
                          + ACC_W'(lane_bias[i]);
         assign y_in[i]   = take ? acc[i][bcir_pkg::Q16_SHIFT +: ADC_BITS] : y_ff[i];
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         d_valid_ff <= 1'b0;
         for (int i = 0; i < NL; i++) begin
            y_ff[i] <= '0;
         end
      end else begin
         d_valid_ff <= d_valid_in;
         for (int i = 0; i < NL; i++) begin
            y_ff[i] <= y_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         mean_ff   <= adc_mean;
         weight_ff <= weight_mean;
      end
   end

   assign rsp_valid      = d_valid_ff;
   assign mean_out       = mean_ff;
   assign weight_out     = weight_ff;
   assign smooth_pot     = y_ff[0];
   assign smooth_battery = y_ff[1];
   assign smooth_current = y_ff[2];

endmodule

`default_nettype wire

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the boxcar average and IIR smoother.
// ----------------------------------------------------------------------------
// Sample sets go in through the valid/stall input in bursts of random length.
// Every result beat is checked field by field against a local model of the
// sample rings and the three low-pass filters. A short directed table covers
// the reset state, the field extremes, weights of zero, one and above one,
// masked upper data bits and an unmapped register. Random phases follow, and
// each phase first programs new weights and reads them back. The result side
// stalls on a pattern that keeps changing. Once, it holds off long enough for
// the pipeline to back up to the input.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

   localparam int AW             = bcir_pkg::DEF_ADC_BITS;
   localparam int WW             = bcir_pkg::WEIGHT_BITS;
   localparam int NA             = bcir_pkg::NUM_ADC;
   localparam int WIN            = bcir_pkg::DEF_WINDOW;
   localparam int AB             = bcir_pkg::ALPHA_BITS;
   localparam int RB             = bcir_pkg::REG_IDX_BITS;
   localparam int DB             = bcir_pkg::CSR_DATA_BITS;
   localparam int ADC_TOP        = 2**AW - 1;
   localparam int WEIGHT_TOP     = 2**WW - 1;
   localparam int NUM_WEIGHTS    = 3;
   localparam int RANDOM_PHASES  = 6;
   localparam int SETS_PER_PHASE = 108;
   localparam int HOLD_AFTER     = 300;
   localparam int HOLD_CYCLES    = 90;
   localparam int QUIET_LIMIT    = 1000;   // well above hold + gap + drain
   localparam logic [RB-1:0] REG_UNMAPPED = 2'd3;

   typedef struct packed {
      logic [AW-1:0] key, pot, battery, current;
      logic [WW-1:0] weight;
   } readings_type;

   typedef struct packed {
      logic [AW-1:0] mean_key, mean_pot, mean_battery, mean_current;
      logic [WW-1:0] mean_weight;
      logic [AW-1:0] smooth_pot, smooth_battery, smooth_current;
   } averages_type;

   typedef enum logic [1:0] {ROW_SET, ROW_PINNED, ROW_WRITE} row_kind_type;
   typedef enum logic [1:0] {MODE_SPREAD, MODE_RAILS, MODE_DRIFT} stim_mode_type;
   typedef enum logic [1:0] {FLOW, LIGHT, HEAVY, EVERY_THIRD} stall_pattern_type;

   typedef struct {
      row_kind_type  kind;
      readings_type  readings;
      averages_type  pinned;
      logic [RB-1:0] index;
      logic [DB-1:0] data;
   } row_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic [AW-1:0]            req_raw_key = '0;
   logic [AW-1:0]            req_raw_pot = '0;
   logic [AW-1:0]            req_raw_battery = '0;
   logic [AW-1:0]            req_raw_current = '0;
   logic [WW-1:0]            req_raw_weight = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic [AW-1:0]            rsp_mean_key, rsp_mean_pot, rsp_mean_battery, rsp_mean_current;
   logic [WW-1:0]            rsp_mean_weight;
   logic [AW-1:0]            rsp_smooth_pot, rsp_smooth_battery, rsp_smooth_current;
   logic                     psel = 1'b0;
   logic                     penable = 1'b0;
   logic                     pwrite = 1'b0;
   logic [bcir_pkg::CSR_ADDR_BITS-1:0] paddr = '0;
   logic [DB-1:0]            pwdata = '0;
   logic [DB-1:0]            prdata;
   logic                     pready;

   always #5 clock = ~clock;

   boxcar_average_iir_smoother dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_raw_key        (req_raw_key),
      .req_raw_pot        (req_raw_pot),
      .req_raw_battery    (req_raw_battery),
      .req_raw_current    (req_raw_current),
      .req_raw_weight     (req_raw_weight),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_mean_key       (rsp_mean_key),
      .rsp_mean_pot       (rsp_mean_pot),
      .rsp_mean_battery   (rsp_mean_battery),
      .rsp_mean_current   (rsp_mean_current),
      .rsp_mean_weight    (rsp_mean_weight),
      .rsp_smooth_pot     (rsp_smooth_pot),
      .rsp_smooth_battery (rsp_smooth_battery),
      .rsp_smooth_current (rsp_smooth_current),
      .psel               (psel),
      .penable            (penable),
      .pwrite             (pwrite),
      .paddr              (paddr),
      .pwdata             (pwdata),
      .prdata             (prdata),
      .pready             (pready)
   );

   // local copy of the rings, filters and weights
   logic [AW-1:0]         adc_ring [NA][WIN];
   logic [WW-1:0]         weight_ring [WIN];
   int unsigned           ring_slot;
   logic [AW-1:0]         pot_level, battery_level, current_level;
   logic [AB-1:0]         alpha [NUM_WEIGHTS];
   averages_type          awaited_averages [$];

   int unsigned sets_sent, results_checked, mismatch_count, weights_written;
   int unsigned burst_left, quiet_cycles, hold_left, pattern_cycle;
   bit          offering, holding, hold_done;
   stall_pattern_type stall_pattern = FLOW;

   function automatic logic [AW-1:0] lowpass(logic [AB-1:0] a, logic [AW-1:0] mean,
         logic [AW-1:0] prev, bit round_half);
      longint unsigned w, acc;
      w = (a > bcir_pkg::Q16_ONE) ? 64'(bcir_pkg::Q16_ONE) : 64'(a);
      acc = w * 64'(mean) + (64'(bcir_pkg::Q16_ONE) - w) * 64'(prev)
          + (round_half ? 64'(bcir_pkg::Q16_HALF) : 64'd0);
      return AW'(acc >> bcir_pkg::Q16_SHIFT);
   endfunction

   function automatic averages_type average_and_smooth(readings_type r);
      averages_type res;
      int unsigned  sums [NA];
      int unsigned  weight_sum;
      adc_ring[bcir_pkg::CH_KEY][ring_slot]     = r.key;
      adc_ring[bcir_pkg::CH_POT][ring_slot]     = r.pot;
      adc_ring[bcir_pkg::CH_BATTERY][ring_slot] = r.battery;
      adc_ring[bcir_pkg::CH_CURRENT][ring_slot] = r.current;
      weight_ring[ring_slot]                    = r.weight;
      ring_slot = (ring_slot + 1) % WIN;
      weight_sum = 0;
      for (int c = 0; c < NA; c++) sums[c] = 0;
      for (int k = 0; k < WIN; k++) begin
         for (int c = 0; c < NA; c++) sums[c] += 32'(adc_ring[c][k]);
         weight_sum += 32'(weight_ring[k]);
      end
      res.mean_key     = AW'(sums[bcir_pkg::CH_KEY] / WIN);
      res.mean_pot     = AW'(sums[bcir_pkg::CH_POT] / WIN);
      res.mean_battery = AW'(sums[bcir_pkg::CH_BATTERY] / WIN);
      res.mean_current = AW'(sums[bcir_pkg::CH_CURRENT] / WIN);
      res.mean_weight  = WW'(weight_sum / WIN);
      pot_level     = lowpass(alpha[bcir_pkg::REG_ALPHA_POT], res.mean_pot,
                              pot_level, 1'b0);
      battery_level = lowpass(alpha[bcir_pkg::REG_ALPHA_BATTERY], res.mean_battery,
                              battery_level, 1'b0);
      current_level = lowpass(alpha[bcir_pkg::REG_ALPHA_CURRENT], res.mean_current,
                              current_level, 1'b1);
      res.smooth_pot     = pot_level;
      res.smooth_battery = battery_level;
      res.smooth_current = current_level;
      return res;
   endfunction

   function automatic readings_type uniform_readings(logic [AW-1:0] adc, logic [WW-1:0] w);
      readings_type r;
      r.key     = adc;
      r.pot     = adc;
      r.battery = adc;
      r.current = adc;
      r.weight  = w;
      return r;
   endfunction

   function automatic row_type make_row(row_kind_type kind, readings_type readings,
         averages_type pinned, logic [RB-1:0] index, logic [DB-1:0] data);
      row_type row;
      row.kind     = kind;
      row.readings = readings;
      row.pinned   = pinned;
      row.index    = index;
      row.data     = data;
      return row;
   endfunction

   function automatic logic [DB-1:0] pick_weight();
      logic [DB-1:0] junk;
      junk = ($urandom_range(0, 3) == 0) ? ($urandom & 32'hFFFE_0000) : '0;
      case ($urandom_range(0, 6))
         0: return junk;
         1: return junk | 32'h1_0000;
         2: return junk | $urandom_range(32'h1_0001, 32'h1_FFFF);
         3: return junk | $urandom_range(1, 255);
         4: return junk | 32'hFFFF;
         default: return junk | $urandom_range(0, 32'hFFFF);
      endcase
   endfunction

   function automatic int unsigned pick_value(stim_mode_type mode, int unsigned prev,
         int unsigned top);
      int stride, moved;
      case (mode)
         MODE_SPREAD: return $urandom_range(0, top);
         MODE_RAILS: begin
            case ($urandom_range(0, 2))
               0: return 0;
               1: return top;
               default: return $urandom_range(0, top);
            endcase
         end
         default: begin
            stride = int'(top / 64);
            moved = int'(prev) + int'($urandom_range(0, 2 * stride)) - stride;
            if (moved < 0) moved = 0;
            if (moved > int'(top)) moved = int'(top);
            return moved;
         end
      endcase
   endfunction

   function automatic readings_type next_readings(stim_mode_type mode, readings_type prev);
      readings_type r;
      r.key     = AW'(pick_value(mode, 32'(prev.key), ADC_TOP));
      r.pot     = AW'(pick_value(mode, 32'(prev.pot), ADC_TOP));
      r.battery = AW'(pick_value(mode, 32'(prev.battery), ADC_TOP));
      r.current = AW'(pick_value(mode, 32'(prev.current), ADC_TOP));
      r.weight  = WW'(pick_value(mode, 32'(prev.weight), WEIGHT_TOP));
      return r;
   endfunction

   task automatic compare_field(string name, logic [WW-1:0] want, logic [WW-1:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatch_count++;
      end
   endtask

   task automatic offer(readings_type r, averages_type pinned, bit use_pinned);
      averages_type predicted;
      req_valid       <= 1'b1;
      req_raw_key     <= r.key;
      req_raw_pot     <= r.pot;
      req_raw_battery <= r.battery;
      req_raw_current <= r.current;
      req_raw_weight  <= r.weight;
      offering = 1'b1;
      do @(posedge clock); while (req_stall);
      predicted = average_and_smooth(r);
      awaited_averages.push_back(use_pinned ? pinned : predicted);
      sets_sent++;
      if (burst_left > 0) burst_left--;
      if (burst_left == 0 && !holding) begin
         req_valid <= 1'b0;
         offering = 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 12);
      end
   endtask

   task automatic drain();
      if (offering) begin
         req_valid <= 1'b0;
         offering = 1'b0;
      end
      while (awaited_averages.size() != 0) @(posedge clock);
   endtask

   task automatic csr_check(logic [RB-1:0] index);
      psel    <= 1'b1;
      pwrite  <= 1'b0;
      penable <= 1'b0;
      paddr   <= {index, 2'b00};
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata !== DB'(alpha[index])) begin
         $error("weight register %0d: expected %0d, got %0d", index, alpha[index], prdata);
         mismatch_count++;
      end
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   // only ever called with the pipeline empty
   task automatic set_weight(logic [RB-1:0] index, logic [DB-1:0] data);
      drain();
      psel    <= 1'b1;
      pwrite  <= 1'b1;
      penable <= 1'b0;
      paddr   <= {index, 2'b00};
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (index <= bcir_pkg::REG_ALPHA_CURRENT) begin
         alpha[index] = data[AB-1:0];
         weights_written++;
      end
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
      if (index <= bcir_pkg::REG_ALPHA_CURRENT) csr_check(index);
      else begin
         csr_check(bcir_pkg::REG_ALPHA_POT);
         csr_check(bcir_pkg::REG_ALPHA_BATTERY);
         csr_check(bcir_pkg::REG_ALPHA_CURRENT);
      end
   endtask

   always @(posedge clock) begin : result_side
      averages_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (awaited_averages.size() == 0) begin
               $error("result beat with nothing awaited");
               mismatch_count++;
            end else begin
               want = awaited_averages.pop_front();
               compare_field("mean_key", WW'(want.mean_key), WW'(rsp_mean_key));
               compare_field("mean_pot", WW'(want.mean_pot), WW'(rsp_mean_pot));
               compare_field("mean_battery", WW'(want.mean_battery),
                             WW'(rsp_mean_battery));
               compare_field("mean_current", WW'(want.mean_current),
                             WW'(rsp_mean_current));
               compare_field("mean_weight", want.mean_weight, rsp_mean_weight);
               compare_field("smooth_pot", WW'(want.smooth_pot), WW'(rsp_smooth_pot));
               compare_field("smooth_battery", WW'(want.smooth_battery),
                             WW'(rsp_smooth_battery));
               compare_field("smooth_current", WW'(want.smooth_current),
                             WW'(rsp_smooth_current));
               results_checked++;
            end
         end
         if (!hold_done && sets_sent >= HOLD_AFTER) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
         end
         pattern_cycle++;
         if (pattern_cycle % 48 == 0)
            stall_pattern = stall_pattern_type'($urandom_range(0, 3));
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            case (stall_pattern)
               FLOW:    rsp_stall <= 1'b0;
               LIGHT:   rsp_stall <= ($urandom_range(0, 3) == 0);
               HEAVY:   rsp_stall <= ($urandom_range(0, 9) < 7);
               default: rsp_stall <= (pattern_cycle % 3 == 0);
            endcase
         end
         holding = (hold_left > 0);
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (psel && penable))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("no beat moved for %0d cycles, %0d results outstanding",
                     quiet_cycles, awaited_averages.size());
            $display("[boxcar_average_iir_smoother] ERROR");
            $finish;
         end
      end
   end

   initial begin
      row_type       rows [$];
      readings_type  r;
      averages_type  zero_res, full_res, tail_res;
      stim_mode_type mode;

      alpha[bcir_pkg::REG_ALPHA_POT]     = bcir_pkg::ALPHA_POT_RST;
      alpha[bcir_pkg::REG_ALPHA_BATTERY] = bcir_pkg::ALPHA_BATTERY_RST;
      alpha[bcir_pkg::REG_ALPHA_CURRENT] = bcir_pkg::ALPHA_CURRENT_RST;
      for (int c = 0; c < NA; c++)
         for (int k = 0; k < WIN; k++) adc_ring[c][k] = '0;
      for (int k = 0; k < WIN; k++) weight_ring[k] = '0;
      ring_slot     = 0;
      pot_level     = '0;
      battery_level = '0;
      current_level = '0;
      burst_left    = $urandom_range(1, 12);

      zero_res = '0;
      full_res = '1;
      // fifteen full sets and one zero set, weights at zero hold the filters
      tail_res = '0;
      tail_res.mean_key       = 12'd3839;
      tail_res.mean_pot       = 12'd3839;
      tail_res.mean_battery   = 12'd3839;
      tail_res.mean_current   = 12'd3839;
      tail_res.mean_weight    = 16'd61439;
      tail_res.smooth_pot     = 12'd4095;
      tail_res.smooth_battery = 12'd4095;
      tail_res.smooth_current = 12'd4095;

      rows.push_back(make_row(ROW_PINNED, uniform_readings('0, '0), zero_res, '0, '0));
      rows.push_back(make_row(ROW_SET, uniform_readings('1, '1), zero_res, '0, '0));
      rows.push_back(make_row(ROW_SET, uniform_readings(12'hAAA, 16'hAAAA), zero_res,
                              '0, '0));
      rows.push_back(make_row(ROW_SET, uniform_readings(12'h555, 16'h5555), zero_res,
                              '0, '0));
      rows.push_back(make_row(ROW_SET, uniform_readings(12'h001, 16'h0001), zero_res,
                              '0, '0));
      rows.push_back(make_row(ROW_SET, uniform_readings(12'h800, 16'h8000), zero_res,
                              '0, '0));
      rows.push_back(make_row(ROW_SET, uniform_readings(12'h7FF, 16'h7FFF), zero_res,
                              '0, '0));
      // weights above one saturate; upper data bits are dropped
      rows.push_back(make_row(ROW_WRITE, '0, zero_res, bcir_pkg::REG_ALPHA_POT,
                              32'h0001_FFFF));
      rows.push_back(make_row(ROW_WRITE, '0, zero_res, bcir_pkg::REG_ALPHA_BATTERY,
                              32'hFFFF_0001));
      rows.push_back(make_row(ROW_WRITE, '0, zero_res, bcir_pkg::REG_ALPHA_CURRENT,
                              32'h0001_0000));
      rows.push_back(make_row(ROW_WRITE, '0, zero_res, REG_UNMAPPED, 32'h0000_0000));
      for (int k = 0; k < WIN - 1; k++)
         rows.push_back(make_row(ROW_SET, uniform_readings('1, '1), zero_res, '0, '0));
      rows.push_back(make_row(ROW_PINNED, uniform_readings('1, '1), full_res, '0, '0));
      rows.push_back(make_row(ROW_WRITE, '0, zero_res, bcir_pkg::REG_ALPHA_POT, 32'h0));
      rows.push_back(make_row(ROW_WRITE, '0, zero_res, bcir_pkg::REG_ALPHA_BATTERY, 32'h0));
      rows.push_back(make_row(ROW_WRITE, '0, zero_res, bcir_pkg::REG_ALPHA_CURRENT, 32'h0));
      rows.push_back(make_row(ROW_PINNED, uniform_readings('0, '0), tail_res, '0, '0));
      rows.push_back(make_row(ROW_SET, uniform_readings(12'h3C5, 16'hC35A), zero_res,
                              '0, '0));

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      csr_check(bcir_pkg::REG_ALPHA_POT);
      csr_check(bcir_pkg::REG_ALPHA_BATTERY);
      csr_check(bcir_pkg::REG_ALPHA_CURRENT);

      foreach (rows[i]) begin
         if (rows[i].kind == ROW_WRITE)
            set_weight(rows[i].index, rows[i].data);
         else
            offer(rows[i].readings, rows[i].pinned, rows[i].kind == ROW_PINNED);
      end

      r = '0;
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         set_weight(bcir_pkg::REG_ALPHA_POT, pick_weight());
         set_weight(bcir_pkg::REG_ALPHA_BATTERY, pick_weight());
         set_weight(bcir_pkg::REG_ALPHA_CURRENT, pick_weight());
         mode = stim_mode_type'(p % 3);
         for (int n = 0; n < SETS_PER_PHASE; n++) begin
            r = next_readings(mode, r);
            offer(r, zero_res, 1'b0);
         end
      end

      drain();
      repeat (12) @(posedge clock);
      $display("%0d sample sets over %0d weight writes, %0d result beats compared",
               sets_sent, weights_written, results_checked);
      $display("spread, rail and drift phases; one %0d-cycle receiver hold", HOLD_CYCLES);
      if (mismatch_count == 0 && awaited_averages.size() == 0)
         $display("[boxcar_average_iir_smoother] OK");
      else
         $display("[boxcar_average_iir_smoother] ERROR");
      $finish;
   end

endmodule

`default_nettype wire
